// ----- rtl/pvtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pvtf_pkg;

   localparam int BINS_DEF       = 1024;
   localparam int PHASE_BITS_DEF = 16;

   localparam int BIN_W          = 10;
   localparam int FREQ_W         = 32;
   localparam int BIN_HZ_W       = 32;
   localparam int OSR_LOG2_W     = 3;
   localparam int OSR_LOG2_MAX   = 5;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 32;

   localparam logic [OSR_LOG2_W-1:0] OSR_LOG2_RST = 3'd2;
   localparam logic [BIN_HZ_W-1:0]   BIN_HZ_RST   = 32'd1536000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OSR_LOG2 = 1'b0,
      CSR_BIN_HZ   = 1'b1
   } csr_idx_type;

endpackage

`default_nettype wire

// ----- rtl/phase_vocoder_true_frequency_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Phase vocoder analysis, true frequency of one FFT bin. Each item carries a bin number and
// its phase (units of pi/2^(PHASE_BITS-1)); the block swaps it against the phase stored for
// that bin in the previous frame, removes the expected advance bin*2pi/osamp, wraps, and
// returns (bin + deviation*osamp/2pi) * bin_hz as signed Q24.8 Hz, saturated to 32 bits.
// One item per cycle unless clearing or rsp_stall stalls; stages s1, s2, s3, then output reg.
// The phase store is a single-port read-first RAM: the old phase is read and the new one
// written at the same address in the acceptance cycle, so back-to-back items on one bin
// need no forwarding. After reset a clearing pass zeroes the store, one entry per cycle,
// from entry 0 to BINS-1; req_stall stays high until it completes. Bins at or above BINS read a
// previous phase of zero and are not stored. Registers: index 0 oversample_log2 (values
// above 5 act as 5), index 1 bin_hz (unsigned Q16.16 Hz); write them only while idle.

module phase_vocoder_true_frequency_top #(
   parameter int BINS       = pvtf_pkg::BINS_DEF,
   parameter int PHASE_BITS = pvtf_pkg::PHASE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [pvtf_pkg::BIN_W-1:0]           req_bin_index,
   input  wire logic signed [PHASE_BITS-1:0]         req_phase,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [pvtf_pkg::BIN_W-1:0]                rsp_bin_out,
   output logic signed [pvtf_pkg::FREQ_W-1:0]        rsp_true_freq,

   input  wire logic                                 csr_we,
   input  wire logic [pvtf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pvtf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pvtf_pkg::*;

   localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int IW = ((AW > BIN_W) ? AW : BIN_W) + 1;
   localparam int NW = BIN_W + PHASE_BITS + 2;
   localparam int PW = NW + BIN_HZ_W + 1;
   localparam int SH = PHASE_BITS + 8;
   localparam int QW = PW - SH;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // configuration
   logic [OSR_LOG2_W-1:0] osr_log2_ff;
   logic [BIN_HZ_W-1:0]   bin_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         osr_log2_ff <= OSR_LOG2_RST;
         bin_hz_ff   <= BIN_HZ_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_OSR_LOG2: osr_log2_ff <= csr_wdata[OSR_LOG2_W-1:0];
            CSR_BIN_HZ:   bin_hz_ff   <= csr_wdata[BIN_HZ_W-1:0];
            default: ;
         endcase
      end
   end

   // clearing sequencer
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            clearing;
   logic            clr_last;

   assign clearing = (state_ff == ST_CLEAR);
   assign clr_last = (clr_ff == AW'(BINS - 1));

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // pipeline flow control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s3_free, s2_free, s1_free;
   logic s3_go, s2_go, s1_go;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_go     = s3_valid_ff && out_free;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_go     = s2_valid_ff && s3_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_go     = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = clearing || !s1_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_go);
   assign s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
   assign s3_valid_in  = s2_go || (s3_valid_ff && !s3_go);
   assign rsp_valid_in = s3_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // phase store: read old, write new in the same cycle
   logic [IW-1:0]         req_bin_ext;
   logic [AW-1:0]         req_addr;
   logic                  req_in_range;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [PHASE_BITS-1:0] mem_wdata;
   logic [PHASE_BITS-1:0] prev_mem [BINS];
   logic [PHASE_BITS-1:0] prev_rd_ff;

   assign req_bin_ext  = IW'(req_bin_index);
   assign req_addr     = req_bin_ext[AW-1:0];
   assign req_in_range = (req_bin_ext < IW'(BINS));
   assign mem_we       = clearing || (accept && req_in_range);
   assign mem_waddr    = clearing ? clr_ff : req_addr;
   assign mem_wdata    = clearing ? '0 : req_phase;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prev_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[req_addr];
      end
   end

   // stage 1: wrap deviation, form (bin<<PHASE_BITS) + (d<<k)
   logic [BIN_W-1:0]            s1_bin_ff;
   logic [PHASE_BITS-1:0]       s1_phase_ff;
   logic                        s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bin_ff      <= req_bin_index;
         s1_phase_ff    <= req_phase;
         s1_in_range_ff <= req_in_range;
      end
   end

   logic [OSR_LOG2_W-1:0]         k;
   logic [PHASE_BITS-1:0]         prev;
   logic [BIN_W+PHASE_BITS-1:0]   adv_wide;
   logic [PHASE_BITS-1:0]         dev_u;
   logic signed [PHASE_BITS-1:0]  dev;
   logic signed [NW-1:0]          n_in;

   assign k        = (osr_log2_ff > OSR_LOG2_W'(OSR_LOG2_MAX)) ?
                     OSR_LOG2_W'(OSR_LOG2_MAX) : osr_log2_ff;
   assign prev     = s1_in_range_ff ? prev_rd_ff : '0;
   assign adv_wide = {s1_bin_ff, {PHASE_BITS{1'b0}}} >> k;
   assign dev_u    = s1_phase_ff - prev - adv_wide[PHASE_BITS-1:0];
   assign dev      = $signed(dev_u);
   assign n_in     = $signed({2'b00, s1_bin_ff, {PHASE_BITS{1'b0}}})
                     + (NW'(dev) <<< k);

   // stage 2: scale by bin_hz
   logic [BIN_W-1:0]      s2_bin_ff;
   logic signed [NW-1:0]  s2_n_ff;

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_bin_ff <= s1_bin_ff;
         s2_n_ff   <= n_in;
      end
   end

   logic signed [PW-1:0] prod_in;

   assign prod_in = s2_n_ff * $signed({1'b0, bin_hz_ff});

   // stage 3: floor shift and saturate
   logic [BIN_W-1:0]      s3_bin_ff;
   logic signed [PW-1:0]  s3_prod_ff;

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_bin_ff  <= s2_bin_ff;
         s3_prod_ff <= prod_in;
      end
   end

   logic [QW-1:0]         q;
   logic [QW-1:FREQ_W-1]  q_hi;
   logic                  q_fits;
   logic [FREQ_W-1:0]     freq_in;

   assign q      = s3_prod_ff[PW-1:SH];
   assign q_hi   = q[QW-1:FREQ_W-1];
   assign q_fits = (&q_hi) || !(|q_hi);
   assign freq_in = q_fits ? q[FREQ_W-1:0] :
                    (q[QW-1] ? {1'b1, {(FREQ_W-1){1'b0}}} : {1'b0, {(FREQ_W-1){1'b1}}});

   // output register
   logic [BIN_W-1:0]   rsp_bin_ff;
   logic [FREQ_W-1:0]  rsp_freq_ff;

   always_ff @(posedge clock) begin
      if (s3_go) begin
         rsp_bin_ff  <= s3_bin_ff;
         rsp_freq_ff <= freq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_out   = rsp_bin_ff;
   assign rsp_true_freq = $signed(rsp_freq_ff);

`ifndef ASSERT_OFF
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (clearing && clr_last) |=> (state_ff == ST_RUN))
      else $error("clearing pass did not end after the last entry");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !rsp_valid_ff))
      else $error("item in flight during clearing pass");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_bin_ff)))
      else $error("stage 1 item lost while blocked");

   a_store_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !clearing) |-> (accept && req_in_range))
      else $error("phase store written outside an in-range item");
`endif

endmodule

`default_nettype wire

// ----- tb/phase_vocoder_true_frequency_top_tb.sv -----
`timescale 1ns / 1ps

module phase_vocoder_true_frequency_top_tb;
   import pvtf_pkg::*;

   localparam int LATENCY   = 4;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic signed [15:0] phase;
   } bin_phase_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic [FREQ_W-1:0] freq;
   } bin_freq_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BIN_W-1:0]       req_bin_index = '0;
   logic signed [15:0]     req_phase = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BIN_W-1:0]       rsp_bin_out;
   logic signed [FREQ_W-1:0] rsp_true_freq;

   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_OSR_LOG2;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bin_phase_type          pending_items[$];
   bin_freq_type           expected_freqs[$];

   logic [15:0]            phase_store [BINS_DEF];
   logic [15:0]            sent_phase [BINS_DEF];
   logic [OSR_LOG2_W-1:0]  osr_log2_cfg = OSR_LOG2_RST;
   logic [BIN_HZ_W-1:0]    bin_hz_cfg = BIN_HZ_RST;

   bit                     idle_enable = 1'b1;
   bit                     long_hold_arm = 1'b0;
   bit                     long_hold_done = 1'b0;
   int                     long_hold_left = 0;
   int                     send_gap = 0;
   int                     recv_gap = 0;
   int                     mismatches = 0;

   phase_vocoder_true_frequency_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_bin_index (req_bin_index),
      .req_phase     (req_phase),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_out   (rsp_bin_out),
      .rsp_true_freq (rsp_true_freq),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < BINS_DEF; i++) begin
         phase_store[i] = '0;
         sent_phase[i] = '0;
      end
   end

   function automatic int capped_log2();
      return (osr_log2_cfg > OSR_LOG2_MAX) ? OSR_LOG2_MAX : int'(osr_log2_cfg);
   endfunction

   // swap the stored phase, wrap the deviation, scale to Q24.8 Hz with saturation
   function automatic bin_freq_type true_freq_of(input logic [BIN_W-1:0] bin,
                                                 input logic [15:0] phase);
      int           k;
      logic [15:0]  prev;
      logic [15:0]  advance;
      logic [15:0]  wrapped;
      longint       dev;
      longint       dev_term;
      longint       sum;
      longint       q;
      bin_freq_type res;
      k = capped_log2();
      prev = phase_store[bin];
      phase_store[bin] = phase;
      advance = 16'(32'(bin) << (16 - k));
      wrapped = phase - prev - advance;
      dev = longint'($signed(wrapped));
      dev_term = dev * (longint'(1) << k) * longint'({32'd0, bin_hz_cfg});
      sum = longint'({54'd0, bin}) * longint'({32'd0, bin_hz_cfg}) + (dev_term >>> 16);
      q = sum >>> 8;
      if (q > longint'(32'sh7FFFFFFF))
         q = longint'(32'sh7FFFFFFF);
      else if (q < -longint'(64'h80000000))
         q = -longint'(64'h80000000);
      res.bin = bin;
      res.freq = q[31:0];
      return res;
   endfunction

   always @(posedge clock) begin : drive_items
      logic          next_valid;
      bin_phase_type next_item;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_freqs.push_back(true_freq_of(req_bin_index, req_phase));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 8);
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_bin_index <= next_item.bin;
               req_phase <= next_item.phase;
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   always @(posedge clock) begin : check_results
      logic         next_stall;
      bin_freq_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_freqs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: bin %0d freq %0d", rsp_bin_out, rsp_true_freq);
         end else begin
            want = expected_freqs.pop_front();
            if (rsp_bin_out !== want.bin || rsp_true_freq !== want.freq) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected bin %0d freq %0d, got bin %0d freq %0d",
                           want.bin, $signed(want.freq), rsp_bin_out, rsp_true_freq);
            end
         end
      end
      if (long_hold_arm && !long_hold_done && rsp_valid) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
         long_hold_left--;
         next_stall = 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         next_stall = 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(0, 8);
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_OSR_LOG2)
         osr_log2_cfg = data[OSR_LOG2_W-1:0];
      else
         bin_hz_cfg = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input logic [BIN_W-1:0] bin, input logic [15:0] phase);
      bin_phase_type it;
      it.bin = bin;
      it.phase = phase;
      sent_phase[bin] = phase;
      pending_items.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_freqs.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function automatic logic [BIN_HZ_W-1:0] pick_bin_hz();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0100_0000);
         2: return BIN_HZ_RST;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // mostly frames of neighboring bins advancing near their expected rate, some noise
   task automatic send_random(input int count);
      int          sent;
      int          first;
      int          len;
      logic [BIN_W-1:0] bin;
      logic [15:0] noise;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            first = $urandom_range(0, BINS_DEF - 1);
            len = $urandom_range(1, 16);
            for (int j = 0; j < len && sent < count; j++) begin
               bin = BIN_W'(first + j);
               noise = 16'($urandom_range(0, 4095)) - 16'd2048;
               send_item(bin, sent_phase[bin] + 16'(32'(bin) << (16 - capped_log2())) + noise);
               sent++;
            end
         end else begin
            send_item(BIN_W'($urandom()), 16'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(10'd0, 16'h0000);
      send_item(10'd1023, 16'h7FFF);
      send_item(10'd1023, 16'h8000);
      send_item(10'd2, 16'h0000);
      send_item(10'd0, 16'h8000);
      send_item(10'd0, 16'h7FFF);
      send_item(10'd1, 16'hFFFF);
      send_item(10'd512, 16'h4000);
      wait_drained();

      write_reg(CSR_OSR_LOG2, 32'd0);
      write_reg(CSR_BIN_HZ, 32'hFFFF_FFFF);
      send_item(10'd1023, 16'h0000);
      send_item(10'd0, 16'h8000);
      send_item(10'd1, 16'h7FFF);
      send_item(10'd1023, 16'h8000);
      wait_drained();

      write_reg(CSR_OSR_LOG2, 32'd5);
      write_reg(CSR_BIN_HZ, 32'd0);
      send_item(10'd5, 16'd100);
      send_item(10'd1023, 16'hFFFF);
      wait_drained();

      write_reg(CSR_OSR_LOG2, 32'd7);
      write_reg(CSR_BIN_HZ, 32'd1);
      send_item(10'd1023, 16'h7FFF);
      send_item(10'd3, 16'h8000);
      wait_drained();

      write_reg(CSR_OSR_LOG2, 32'd6);
      write_reg(CSR_BIN_HZ, 32'h8000_0000);
      send_item(10'd1023, 16'd12345);
      send_item(10'd0, 16'h8000);
      send_item(10'd700, 16'hFFFE);
      wait_drained();

      long_hold_arm = 1'b1;
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_OSR_LOG2, 32'($urandom_range(0, 7)));
         write_reg(CSR_BIN_HZ, pick_bin_hz());
         if (p == 4)
            idle_enable = 1'b0;
         send_random(106);
         wait_drained();
      end

      repeat (LATENCY * 4) @(posedge clock);
      if (mismatches == 0 && expected_freqs.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
